/* hw/rtl/cbez_pkg.sv */
// cbez_pkg: shared widths, payload types and the fixed-point lerp helper
// depends on nothing; used by every module of cubic_bezier_point
package cbez_pkg;

   localparam int COORD_WIDTH = 32;
   localparam int FRAC_BITS   = 16;
   localparam int TIME_WIDTH  = 16;
   localparam int T_WIDTH     = FRAC_BITS + 1;
   localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_WIDTH  = $clog2(QUEUE_DEPTH);

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic [T_WIDTH-1:0] tval_type;
   typedef logic [TIME_WIDTH-1:0] time_type;

   typedef struct packed {
      coord_type p0;
      coord_type p1;
      coord_type p2;
      coord_type p3;
   } axis_type;

   typedef struct packed {
      axis_type  ax;
      axis_type  ay;
      time_type  elapsed;
      time_type  duration;
   } item_type;

   typedef struct packed {
      axis_type  ax;
      axis_type  ay;
      tval_type  t;
      logic      in_progress;
   } work_type;

   // a + floor((b - a) * t / 2^FRAC_BITS); t is at most 1.0 so the result stays in range
   function automatic coord_type lerp_fx(coord_type a, coord_type b, tval_type t);
      logic signed [DIFF_WIDTH-1:0]           d;
      logic signed [DIFF_WIDTH+T_WIDTH:0]     p;
      logic signed [DIFF_WIDTH+T_WIDTH:0]     s;
      d = DIFF_WIDTH'(b) - DIFF_WIDTH'(a);
      p = (DIFF_WIDTH+T_WIDTH+1)'(d) * $signed({1'b0, t});
      s = p >>> FRAC_BITS;
      return coord_type'(a + coord_type'(s));
   endfunction

endpackage

/* hw/rtl/cubic_bezier_point.sv */
// cubic_bezier_point: one point of a 2D cubic Bezier curve per item
// depends on cbez_pkg, cbez_front, cbez_queue, cbez_back
//
// usage: req_ channel brings four control points (Q16.16) plus elapsed and
// duration; rsp_ channel returns point_x, point_y and in_progress.
// t = elapsed / duration as a 17-bit fraction, forced to 1.0 once elapsed
// reaches duration or when duration is zero.
// path: the accepting edge loads the divider input register, the divider
// stages produce the quotient bits, then the item passes through the queue
// and three lerp rounds in the back before rsp_valid rises.
// throughput: one beat per cycle on both sides when nothing stalls; the
// divider pipeline sets it. a stalled receiver holds the back stages;
// the four-entry queue absorbs what the divider has in flight until it
// too fills, then req_ready drops.
// reset clears all valid flags; no results are in flight afterwards.
module cubic_bezier_point (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  cbez_pkg::coord_type  req_start_x,
   input  cbez_pkg::coord_type  req_start_y,
   input  cbez_pkg::coord_type  req_ctrl1_x,
   input  cbez_pkg::coord_type  req_ctrl1_y,
   input  cbez_pkg::coord_type  req_ctrl2_x,
   input  cbez_pkg::coord_type  req_ctrl2_y,
   input  cbez_pkg::coord_type  req_finish_x,
   input  cbez_pkg::coord_type  req_finish_y,
   input  cbez_pkg::time_type   req_elapsed,
   input  cbez_pkg::time_type   req_duration,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output cbez_pkg::coord_type  rsp_point_x,
   output cbez_pkg::coord_type  rsp_point_y,
   output logic                 rsp_in_progress
);
   import cbez_pkg::*;

   item_type  item;
   work_type  f_work, q_work;
   logic      f_valid, f_ready, q_valid, q_ready;

   assign item.ax = '{p0: req_start_x, p1: req_ctrl1_x, p2: req_ctrl2_x, p3: req_finish_x};
   assign item.ay = '{p0: req_start_y, p1: req_ctrl1_y, p2: req_ctrl2_y, p3: req_finish_y};
   assign item.elapsed  = req_elapsed;
   assign item.duration = req_duration;

   cbez_front u_front (
      .clock(clock), .reset(reset),
      .in_valid(req_valid), .in_item(item), .in_ready(req_ready),
      .out_valid(f_valid), .out_work(f_work), .out_ready(f_ready)
   );

   cbez_queue u_queue (
      .clock(clock), .reset(reset),
      .in_valid(f_valid), .in_work(f_work), .in_ready(f_ready),
      .out_valid(q_valid), .out_work(q_work), .out_ready(q_ready)
   );

   cbez_back u_back (
      .clock(clock), .reset(reset),
      .in_valid(q_valid), .in_work(q_work), .in_ready(q_ready),
      .out_valid(rsp_valid), .out_x(rsp_point_x), .out_y(rsp_point_y),
      .out_prog(rsp_in_progress), .out_ready(rsp_ready)
   );
endmodule

/* hw/rtl/cbez_front.sv */
// cbez_front: accepts items and forms t = elapsed / duration with a pipelined
// restoring divider, one quotient bit per stage; depends on cbez_pkg
module cbez_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  cbez_pkg::item_type  in_item,
   output logic                in_ready,
   output logic                out_valid,
   output cbez_pkg::work_type  out_work,
   input  logic                out_ready
);
   import cbez_pkg::*;

   localparam int NSTG = FRAC_BITS + 1;
   localparam int RW   = TIME_WIDTH + 1;

   logic [NSTG:0]           vld_ff, vld_in;
   axis_type                ax_ff   [NSTG+1];
   axis_type                ay_ff   [NSTG+1];
   logic [RW-1:0]           rem_ff  [NSTG+1];
   time_type                den_ff  [NSTG+1];
   tval_type                q_ff    [NSTG+1];
   logic                    sat_ff  [NSTG+1];
   logic                    prog_ff [NSTG+1];
   logic                    adv;

   assign adv      = out_ready || !vld_ff[NSTG];
   assign in_ready = adv;
   assign out_valid = vld_ff[NSTG];
   assign out_work.ax = ax_ff[NSTG];
   assign out_work.ay = ay_ff[NSTG];
   assign out_work.t  = sat_ff[NSTG] ? tval_type'(1 << FRAC_BITS) : q_ff[NSTG];
   assign out_work.in_progress = prog_ff[NSTG];

   always_comb begin
      vld_in = {vld_ff[NSTG-1:0], in_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   // stage 0 registers the item; stage k produces quotient bit FRAC_BITS-k+1
   always_ff @(posedge clock) begin
      if (adv) begin
         ax_ff[0]   <= in_item.ax;
         ay_ff[0]   <= in_item.ay;
         rem_ff[0]  <= RW'(in_item.elapsed);
         den_ff[0]  <= in_item.duration;
         q_ff[0]    <= '0;
         sat_ff[0]  <= (in_item.duration == '0) || (in_item.elapsed >= in_item.duration);
         prog_ff[0] <= in_item.elapsed <= in_item.duration;
         for (int k = 1; k <= NSTG; k++) begin
            logic [RW-1:0] r2;
            r2 = (k == 1) ? rem_ff[k-1] : {rem_ff[k-1][RW-2:0], 1'b0};
            ax_ff[k]   <= ax_ff[k-1];
            ay_ff[k]   <= ay_ff[k-1];
            den_ff[k]  <= den_ff[k-1];
            sat_ff[k]  <= sat_ff[k-1];
            prog_ff[k] <= prog_ff[k-1];
            if (r2 >= RW'(den_ff[k-1])) begin
               rem_ff[k] <= r2 - RW'(den_ff[k-1]);
               q_ff[k]   <= {q_ff[k-1][T_WIDTH-2:0], 1'b1};
            end else begin
               rem_ff[k] <= r2;
               q_ff[k]   <= {q_ff[k-1][T_WIDTH-2:0], 1'b0};
            end
         end
      end
   end

   // elapsed below duration keeps the remainder below duration, so quotient fits
   a_sat_prog: assert property (@(posedge clock) disable iff (reset)
      out_valid && !out_work.in_progress |-> out_work.t == tval_type'(1 << FRAC_BITS))
      else $error("past-duration item without full t");
   a_t_range: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> out_work.t <= tval_type'(1 << FRAC_BITS))
      else $error("t above one");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      out_valid && !out_ready |=> out_valid && $stable(out_work))
      else $error("front output changed while stalled");
endmodule

/* hw/rtl/cbez_queue.sv */
// cbez_queue: short fifo between the divider front and the interpolation back
// depends on cbez_pkg
module cbez_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  cbez_pkg::work_type  in_work,
   output logic                in_ready,
   output logic                out_valid,
   output cbez_pkg::work_type  out_work,
   input  logic                out_ready
);
   import cbez_pkg::*;

   work_type                mem_ff [QUEUE_DEPTH];
   logic [QPTR_WIDTH-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [QPTR_WIDTH:0]     cnt_ff, cnt_in;
   logic                    push, pop;

   assign in_ready  = cnt_ff != (QPTR_WIDTH+1)'(QUEUE_DEPTH);
   assign out_valid = cnt_ff != '0;
   assign out_work  = mem_ff[rd_ff];
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;

   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (QPTR_WIDTH+1)'(push) - (QPTR_WIDTH+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= in_work;
      end
   end

   a_cnt: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (QPTR_WIDTH+1)'(QUEUE_DEPTH))
      else $error("queue count overflow");
   a_ptr: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == '0 || cnt_ff == (QPTR_WIDTH+1)'(QUEUE_DEPTH)) |-> wr_ff == rd_ff)
      else $error("queue pointers disagree with count");
   a_cnt_step: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> cnt_ff == $past(cnt_ff) + 1'b1)
      else $error("queue count did not follow a push");
endmodule

/* hw/rtl/cbez_back.sv */
// cbez_back: three registered rounds of lerp on both axes; the third round's registers drive the outputs
// depends on cbez_pkg
module cbez_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  cbez_pkg::work_type  in_work,
   output logic                in_ready,
   output logic                out_valid,
   output cbez_pkg::coord_type out_x,
   output cbez_pkg::coord_type out_y,
   output logic                out_prog,
   input  logic                out_ready
);
   import cbez_pkg::*;

   logic [2:0]  vld_ff;
   logic        adv;
   tval_type    t1_ff, t2_ff;
   logic        pg1_ff, pg2_ff, pg3_ff;
   coord_type   xa0_ff, xa1_ff, xa2_ff, ya0_ff, ya1_ff, ya2_ff;
   coord_type   xb0_ff, xb1_ff, yb0_ff, yb1_ff;
   coord_type   x_ff, y_ff;

   assign adv       = out_ready || !vld_ff[2];
   assign in_ready  = adv;
   assign out_valid = vld_ff[2];
   assign out_x     = x_ff;
   assign out_y     = y_ff;
   assign out_prog  = pg3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         xa0_ff <= lerp_fx(in_work.ax.p0, in_work.ax.p1, in_work.t);
         xa1_ff <= lerp_fx(in_work.ax.p1, in_work.ax.p2, in_work.t);
         xa2_ff <= lerp_fx(in_work.ax.p2, in_work.ax.p3, in_work.t);
         ya0_ff <= lerp_fx(in_work.ay.p0, in_work.ay.p1, in_work.t);
         ya1_ff <= lerp_fx(in_work.ay.p1, in_work.ay.p2, in_work.t);
         ya2_ff <= lerp_fx(in_work.ay.p2, in_work.ay.p3, in_work.t);
         t1_ff  <= in_work.t;
         pg1_ff <= in_work.in_progress;
         xb0_ff <= lerp_fx(xa0_ff, xa1_ff, t1_ff);
         xb1_ff <= lerp_fx(xa1_ff, xa2_ff, t1_ff);
         yb0_ff <= lerp_fx(ya0_ff, ya1_ff, t1_ff);
         yb1_ff <= lerp_fx(ya1_ff, ya2_ff, t1_ff);
         t2_ff  <= t1_ff;
         pg2_ff <= pg1_ff;
         x_ff   <= lerp_fx(xb0_ff, xb1_ff, t2_ff);
         y_ff   <= lerp_fx(yb0_ff, yb1_ff, t2_ff);
         pg3_ff <= pg2_ff;
      end
   end

   a_hold: assert property (@(posedge clock) disable iff (reset)
      out_valid && !out_ready |=> out_valid && $stable(x_ff) && $stable(y_ff))
      else $error("result changed while stalled");
   a_endpt: assert property (@(posedge clock) disable iff (reset)
      adv && vld_ff[1] && t2_ff == tval_type'(1 << FRAC_BITS) |=> x_ff == $past(xb1_ff))
      else $error("full t did not give the end point");
   a_flow: assert property (@(posedge clock) disable iff (reset)
      adv && vld_ff[1] |=> out_valid)
      else $error("item lost in back stages");
endmodule

/* test/tb_cubic_bezier_point.sv */
// tb_cubic_bezier_point: self-checking bench for the cubic bezier point evaluator
// depends on cbez_pkg and cubic_bezier_point; drives random bursts, checks every beat
module tb_cubic_bezier_point;
   timeunit 1ns;
   timeprecision 1ps;
   import cbez_pkg::*;

   typedef struct {
      coord_type sx, sy, c1x, c1y, c2x, c2y, fx, fy;
      time_type  el, du;
   } curve_req_type;

   typedef struct {
      coord_type px, py;
      logic      busy;
   } curve_pt_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   coord_type req_start_x = '0, req_start_y = '0, req_ctrl1_x = '0, req_ctrl1_y = '0;
   coord_type req_ctrl2_x = '0, req_ctrl2_y = '0, req_finish_x = '0, req_finish_y = '0;
   time_type  req_elapsed = '0, req_duration = 16'd1;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   coord_type rsp_point_x, rsp_point_y;
   logic rsp_in_progress;

   curve_req_type pending_q[$];
   curve_pt_type  point_q[$];
   int  mismatches = 0;
   int  gap_left = 0, burst_left = 0;
   int  stall_phase = 0;

   cubic_bezier_point i_dut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic longint lerp_ax(longint a, longint b, longint t);
      longint d, lo, hi;
      d  = b - a;
      lo = d & 64'hFFFF;
      hi = (d - lo) >>> FRAC_BITS;
      return a + hi * t + ((lo * t) >>> FRAC_BITS);
   endfunction

   function automatic coord_type bezier_axis(coord_type p0, coord_type p1, coord_type p2,
                                             coord_type p3, longint t);
      longint a0, a1, a2, b0, b1;
      a0 = lerp_ax(p0, p1, t);
      a1 = lerp_ax(p1, p2, t);
      a2 = lerp_ax(p2, p3, t);
      b0 = lerp_ax(a0, a1, t);
      b1 = lerp_ax(a1, a2, t);
      return coord_type'(lerp_ax(b0, b1, t));
   endfunction

   function automatic curve_pt_type eval_point(curve_req_type r);
      curve_pt_type p;
      longint t;
      if (r.du != 0 && r.el < r.du) t = (longint'(r.el) << FRAC_BITS) / r.du;
      else t = longint'(1) << FRAC_BITS;
      p.px   = bezier_axis(r.sx, r.c1x, r.c2x, r.fx, t);
      p.py   = bezier_axis(r.sy, r.c1y, r.c2y, r.fy, t);
      p.busy = (r.el <= r.du);
      return p;
   endfunction

   function automatic coord_type rand_coord(int mode);
      case (mode)
         0: return coord_type'($urandom);
         1: return coord_type'($urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000);
         default: return coord_type'($signed($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000);
      endcase
   endfunction

   function automatic curve_req_type rand_req();
      curve_req_type r;
      int m;
      m = $urandom_range(0, 9) < 6 ? 0 : ($urandom_range(0, 4) == 0 ? 1 : 2);
      r.sx = rand_coord(m); r.sy = rand_coord(m); r.c1x = rand_coord(m); r.c1y = rand_coord(m);
      r.c2x = rand_coord(m); r.c2y = rand_coord(m); r.fx = rand_coord(m); r.fy = rand_coord(m);
      case ($urandom_range(0, 5))
         0: begin r.du = $urandom_range(1, 65535); r.el = $urandom; end
         1: begin r.du = $urandom_range(1, 16); r.el = $urandom_range(0, 20); end
         2: begin r.du = $urandom_range(1, 65535); r.el = r.du; end
         3: begin r.du = $urandom; r.el = $urandom; end
         default: begin r.du = $urandom_range(1, 65535); r.el = $urandom_range(0, r.du); end
      endcase
      return r;
   endfunction

   function automatic curve_req_type all_coords(coord_type v, time_type el, time_type du);
      curve_req_type r;
      r.sx = v; r.sy = v; r.c1x = v; r.c1y = v; r.c2x = v; r.c2y = v; r.fx = v; r.fy = v;
      r.el = el; r.du = du;
      return r;
   endfunction

   // driver: bursts with random gaps, valid held until the beat is taken
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (pending_q.size() != 0 && gap_left == 0) begin
            curve_req_type r;
            r = pending_q.pop_front();
            point_q.push_back(eval_point(r));
            req_valid <= 1'b1;
            req_start_x <= r.sx; req_start_y <= r.sy;
            req_ctrl1_x <= r.c1x; req_ctrl1_y <= r.c1y;
            req_ctrl2_x <= r.c2x; req_ctrl2_y <= r.c2y;
            req_finish_x <= r.fx; req_finish_y <= r.fy;
            req_elapsed <= r.el; req_duration <= r.du;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 40);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end else begin
               burst_left = burst_left - 1;
            end
         end else begin
            req_valid <= 1'b0;
            if (gap_left > 0) gap_left = gap_left - 1;
         end
      end
   end

   // receiver stall pattern: long open stretches, then choppy stretches
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         stall_phase <= (stall_phase + 1) % 600;
         if (stall_phase < 200) rsp_ready <= 1'b1;
         else if (stall_phase < 400) rsp_ready <= ($urandom_range(0, 3) != 0);
         else rsp_ready <= (stall_phase % 23) < 5;
      end
   end

   // monitor: compare each result beat against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (point_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result beat x=%h y=%h",
                                           rsp_point_x, rsp_point_y);
         end else begin
            curve_pt_type e;
            e = point_q.pop_front();
            if (e.px !== rsp_point_x || e.py !== rsp_point_y || e.busy !== rsp_in_progress) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected x=%h y=%h prog=%b, got x=%h y=%h prog=%b",
                           e.px, e.py, e.busy, rsp_point_x, rsp_point_y, rsp_in_progress);
            end
         end
      end
   end

   initial begin
      #2_000_000;
      $display("status: fail");
      $finish;
   end

   initial begin
      curve_req_type r;
      // directed: extremes of coordinates and of the time fields
      pending_q.push_back(all_coords(32'sh7FFF_FFFF, 16'd0, 16'd1));
      pending_q.push_back(all_coords(32'sh8000_0000, 16'hFFFF, 16'hFFFF));
      pending_q.push_back(all_coords(32'sh0, 16'hFFFF, 16'd1));
      r = all_coords(32'sh8000_0000, 16'd1, 16'd2);
      r.c1x = 32'sh7FFF_FFFF; r.c2y = 32'sh7FFF_FFFF; r.fx = 32'sh7FFF_FFFF;
      pending_q.push_back(r);
      r.el = 16'd0; pending_q.push_back(r);
      r.el = 16'hFFFE; r.du = 16'hFFFF; pending_q.push_back(r);
      r.el = 16'd3; r.du = 16'd2; pending_q.push_back(r);       // elapsed past duration
      r.el = 16'd0; r.du = 16'd0; pending_q.push_back(r);       // zero duration, not begun
      r.el = 16'd5; r.du = 16'd0; pending_q.push_back(r);       // zero duration, begun
      r = all_coords(32'shFFFF_FFFF, 16'h5555, 16'hAAAA);
      r.sx = 32'sh5555_5555; r.fy = 32'shAAAA_AAAA; pending_q.push_back(r);
      r.el = 16'd1; r.du = 16'hFFFF; pending_q.push_back(r);
      r.el = 16'h8000; r.du = 16'h8001; pending_q.push_back(r);
      r.el = 16'h7FFF; r.du = 16'h8000; pending_q.push_back(r);
      for (int i = 0; i < 850; i++) pending_q.push_back(rand_req());
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      wait (pending_q.size() == 0);
      @(posedge clock);
      while (req_valid) @(posedge clock);
      wait (point_q.size() == 0);
      repeat (40) @(posedge clock);
      if (mismatches == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end
endmodule

/* filelist.f */
hw/rtl/cbez_pkg.sv
hw/rtl/cbez_front.sv
hw/rtl/cbez_queue.sv
hw/rtl/cbez_back.sv
hw/rtl/cubic_bezier_point.sv
test/tb_cubic_bezier_point.sv
